>>> src/inetck_pkg.sv
// ----------------------------------------------------------------------------
// inetck_pkg
// Shared types, constants and helpers for the internet checksum engine.
// ----------------------------------------------------------------------------
`default_nettype none

package inetck_pkg;

  localparam int unsigned LEN_BITS = 16;

  localparam logic [1:0] MODE_IP  = 2'd0;
  localparam logic [1:0] MODE_UDP = 2'd1;
  localparam logic [1:0] MODE_TCP = 2'd2;

  localparam logic [15:0] PROTO_UDP = 16'd17;
  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [15:0] WORD_MASK = 16'hFFFF;
  localparam logic [31:0] HDR_BYTES = 32'd8;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic [1:0] mode;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] checksum_value;
  } result_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

>>> src/inetck_core.sv
// ----------------------------------------------------------------------------
// inetck_core
// Running ones' complement sum, byte pairing, and final checksum with the
// optional pseudo-header terms.
// ----------------------------------------------------------------------------
`default_nettype none

module inetck_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  inetck_pkg::item_t     item_i,
  output inetck_pkg::result_t   result_o
);
  import inetck_pkg::*;

  logic [15:0]         sum_q, sum_d;
  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic [7:0]          hold_q, hold_d;
  logic                odd_q, odd_d;
  logic [1:0]          mode_q, mode_d;
  logic                in_region_q, in_region_d;

  logic                first;
  logic [15:0]         sum_base;
  logic [LEN_BITS-1:0] cnt_base;
  logic [7:0]          hold_base;
  logic                odd_base;
  logic [31:0]         cnt_ext;
  logic [15:0]         len_term;
  logic [15:0]         fin;
  logic                take;

  assign take = en_i & item_i.valid;
  assign first = ~in_region_q;

  always_comb begin
    sum_base  = first ? 16'd0 : sum_q;
    cnt_base  = first ? '0 : cnt_q;
    hold_base = first ? 8'd0 : hold_q;
    odd_base  = first ? 1'b0 : odd_q;
    mode_d    = first ? item_i.mode : mode_q;

    if (odd_base) begin
      sum_d  = oc_add(sum_base, {hold_base, item_i.data_byte});
      hold_d = hold_base;
      odd_d  = 1'b0;
    end else begin
      sum_d  = sum_base;
      hold_d = item_i.data_byte;
      odd_d  = 1'b1;
    end
    cnt_d       = cnt_base + LEN_BITS'(1);
    in_region_d = ~item_i.last;

    cnt_ext  = 32'(cnt_d);
    len_term = 16'(cnt_ext - HDR_BYTES);

    fin = sum_d;
    if (odd_d) begin
      fin = oc_add(fin, {hold_d, 8'd0});
    end
    if (mode_d == MODE_UDP || mode_d == MODE_TCP) begin
      fin = oc_add(fin, (mode_d == MODE_UDP) ? PROTO_UDP : PROTO_TCP);
      fin = oc_add(fin, len_term);
    end

    result_o.valid          = item_i.valid & item_i.last;
    result_o.checksum_value = fin ^ WORD_MASK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      hold_q      <= '0;
      odd_q       <= 1'b0;
      mode_q      <= MODE_IP;
      in_region_q <= 1'b0;
    end else if (take) begin
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      odd_q       <= odd_d;
      mode_q      <= mode_d;
      in_region_q <= in_region_d;
    end
  end

endmodule

`default_nettype wire

>>> src/internet_checksum_engine_unit.sv
// ----------------------------------------------------------------------------
// internet_checksum_engine_unit
// Internet checksum over a byte stream, one byte per transaction, with
// optional UDP/TCP pseudo-header terms.
// ----------------------------------------------------------------------------
// Bytes enter one per clock, unless in_stall_o is high, through an input
// register. From there the running sum is updated and, on the byte marked
// last, the checksum is written to the output register at the same edge.
// Sustained throughput is one byte per clock while the output is not
// stalled. The mode is sampled on the first byte of each region. In UDP or
// TCP mode the stream must start with the source and destination IP
// addresses; the protocol number and the length (byte count minus 8) are
// added automatically. While a checksum waits in the output register under
// stall, the input is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module internet_checksum_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      checksum_value_o
);
  import inetck_pkg::*;

  logic        en;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic [1:0]  s1_mode_q;
  logic        s1_last_q;
  logic        out_valid_q;
  logic [15:0] out_value_q;
  item_t       item;
  result_t     result;

  // pipeline moves unless a checksum is held under stall
  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  assign item.valid     = s1_valid_q;
  assign item.data_byte = s1_byte_q;
  assign item.mode      = s1_mode_q;
  assign item.last      = s1_last_q;

  inetck_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .item_i   (item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_byte_q <= data_byte_i;
      s1_mode_q <= mode_i;
      s1_last_q <= last_i;
      if (result.valid) begin
        out_value_q <= result.checksum_value;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign checksum_value_o = out_value_q;

endmodule

`default_nettype wire

>>> tb/tb_internet_checksum_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_internet_checksum_engine_unit
// Self-checking testbench for the internet checksum engine. Byte regions
// are streamed in every mode, including the reserved one, with random gaps
// on the source side and random stall on the sink side. A scoreboard class
// keeps its own running ones' complement sum, byte count and pseudo-header
// terms. It compares every checksum the block returns with the oldest
// expected value.
// ----------------------------------------------------------------------------

module tb_internet_checksum_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import inetck_pkg::*;

  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [1:0] MODE_RSVD       = 2'd3;
  localparam int unsigned RANDOM_BYTES    = 500;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  class checksum_scoreboard;
    logic [15:0]         acc;
    logic [LEN_BITS-1:0] nbytes;
    logic [7:0]          hi_byte;
    bit                  half_word;
    logic [1:0]          region_mode;
    bit                  in_region;
    logic [15:0]         sums_q[$];
    int unsigned         bytes_seen;
    int unsigned         sums_checked;
    int unsigned         errors;
    int unsigned         regions_by_mode[4];

    function new();
      clear();
      bytes_seen   = 0;
      sums_checked = 0;
      errors       = 0;
      foreach (regions_by_mode[i]) regions_by_mode[i] = 0;
    endfunction

    function void clear();
      acc         = 16'h0000;
      nbytes      = '0;
      hi_byte     = 8'h00;
      half_word   = 1'b0;
      region_mode = MODE_IP;
      in_region   = 1'b0;
    endfunction

    // end-around carry add
    function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function void note_byte(logic [7:0] b, logic [1:0] m, logic l);
      logic [15:0] s;
      logic [31:0] len_term;
      bytes_seen++;
      if (!in_region) begin
        clear();
        region_mode = m;
        in_region   = 1'b1;
      end
      if (half_word) begin
        acc       = fold_add(acc, {hi_byte, b});
        half_word = 1'b0;
      end else begin
        hi_byte   = b;
        half_word = 1'b1;
      end
      nbytes = nbytes + 1'b1;
      if (l) begin
        s = acc;
        if (half_word) s = fold_add(s, {hi_byte, 8'h00});
        if (region_mode == MODE_UDP || region_mode == MODE_TCP) begin
          s        = fold_add(s, (region_mode == MODE_UDP) ? PROTO_UDP : PROTO_TCP);
          len_term = 32'(nbytes) - HDR_BYTES;
          s        = fold_add(s, len_term[15:0]);
        end
        sums_q.push_back(~s);
        regions_by_mode[region_mode]++;
        clear();
      end
    endfunction

    function void check_sum(logic [15:0] actual);
      logic [15:0] want;
      if (sums_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected checksum 0x%04h with nothing pending", actual);
      end else begin
        want = sums_q.pop_front();
        sums_checked++;
        if (actual !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("checksum mismatch on region %0d: expected 0x%04h actual 0x%04h",
                     sums_checked, want, actual);
        end
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = 8'h00;
  logic [1:0]  mode_i       = MODE_IP;
  logic        last_i       = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [15:0] checksum_value_o;

  checksum_scoreboard sb;
  bit          sender_quiet  = 1'b0;
  bit          pressure_done = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned random_sent   = 0;

  internet_checksum_engine_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .mode_i           (mode_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .checksum_value_o (checksum_value_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_byte(data_byte_i, mode_i, last_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sum(checksum_value_o);
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'hFF;
    if (r == 1) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // sink side stall, with one long hold-off once results are flowing
  initial begin
    int unsigned hold_left;
    bit          quiet_out;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      quiet_out = ((cycle_count / 256) % 4) == 3;
      if (hold_left == 0) begin
        if (!pressure_done && sb != null && sb.sums_checked >= 6) begin
          pressure_done = 1'b1;
          hold_left     = HOLD_OFF_CYCLES;
        end else if (!quiet_out && $urandom_range(0, 2) == 0) begin
          hold_left = idle_len();
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("internet_checksum_engine_unit test failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic [1:0] m, input logic l);
    int unsigned gap;
    gap = sender_quiet ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    mode_i      <= m;
    last_i      <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // bytes taken msb first from the low n bytes of the vector
  task automatic send_bytes(input logic [1:0] m, input logic [63:0] bytes, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_byte(bytes[8*(n-1-i) +: 8], (i == 0) ? m : 2'($urandom_range(0, 3)), i == n - 1);
  endtask

  task automatic send_random_region(input logic [1:0] m, input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(rand_byte(), (i == 0) ? m : 2'($urandom_range(0, 3)), i == len - 1);
  endtask

  initial begin
    int unsigned pick;
    int unsigned region_len;
    logic [1:0]  region_mode;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single bytes in every mode, carries, short and odd regions
    send_bytes(MODE_IP,   64'hFF, 1);
    send_bytes(MODE_UDP,  64'h00, 1);
    send_bytes(MODE_TCP,  64'hAB, 1);
    send_bytes(MODE_RSVD, 64'h5A, 1);
    send_bytes(MODE_IP,   64'hFFFF, 2);
    send_bytes(MODE_UDP,  64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_bytes(MODE_TCP,  64'h00_FF80_017F, 5);
    send_bytes(MODE_IP,   64'hFFFF_FFFF, 4);

    while (random_sent < RANDOM_BYTES) begin
      pick        = $urandom_range(0, 99);
      region_mode = (pick < 10) ? MODE_RSVD : 2'($urandom_range(0, 2));
      pick        = $urandom_range(0, 99);
      if (pick < 15)      region_len = $urandom_range(1, 7);
      else if (pick < 90) region_len = $urandom_range(8, 24);
      else                region_len = $urandom_range(25, 64);
      sender_quiet = ($urandom_range(0, 7) == 0);
      send_random_region(region_mode, region_len);
      random_sent += region_len;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.sums_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d bytes in %0d regions (ip %0d, udp %0d, tcp %0d, reserved %0d)",
             sb.bytes_seen, sb.sums_checked, sb.regions_by_mode[0], sb.regions_by_mode[1],
             sb.regions_by_mode[2], sb.regions_by_mode[3]);
    $display("summary: random gaps both sides and a %0d-cycle sink hold-off under load",
             HOLD_OFF_CYCLES);
    if (sb.errors == 0 && sb.sums_q.size() == 0) begin
      $display("internet_checksum_engine_unit test passed");
    end else begin
      $display("%0d errors", sb.errors);
      $display("internet_checksum_engine_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/inetck_pkg.sv
src/inetck_core.sv
src/internet_checksum_engine_unit.sv
tb/tb_internet_checksum_engine_unit.sv
